### rtl/core/byte_swap_and_bcd_converter_top_assert.svh
// Assertion macros for the byte swap and BCD converter.
// Expects clk and rst_n in the scope that uses them.
`ifndef BYTE_SWAP_AND_BCD_CONVERTER_TOP_ASSERT_SVH
`define BYTE_SWAP_AND_BCD_CONVERTER_TOP_ASSERT_SVH

// same-cycle implication
`define BSBCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSBCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/bsbcd_pkg.sv
// Shared types, mode codes and word helpers for the byte swap / BCD converter.
// No dependencies.
package bsbcd_pkg;

  localparam int unsigned DATA_W   = 64;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned PAIRS    = 8;   // digit pairs in a word
  localparam int unsigned NIB_STEP = 4;   // binary bits consumed per dabble step
  localparam int unsigned DABBLE_STEPS = 14; // 56 bits cover any value below 10^16
  localparam int unsigned CNT_W    = 4;

  localparam logic [DATA_W-1:0] BCD_LIMIT = 64'd10000000000000000;

  localparam logic [MODE_W-1:0] MODE_SWAP16   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SWAP32   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SWAP64   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TO_BCD   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FROM_BCD = 3'd4;
  localparam logic [MODE_W-1:0] MODE_TO_REV   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_FROM_REV = 3'd6;

  typedef enum logic {
    ALU_HORNER,   // acc * 100 + digit pair
    ALU_DABBLE    // four shift-and-adjust steps
  } alu_op_t;

  typedef struct packed {
    alu_op_t         op;
    logic [7:0]      pair;  // packed BCD byte for the Horner step
    logic [3:0]      bits;  // next binary bits, msb first, for dabble
  } alu_ctl_t;

  function automatic logic [DATA_W-1:0] swap16(input logic [DATA_W-1:0] v);
    swap16 = ((v >> 8) & 64'h00ff00ff00ff00ff) | ((v << 8) & 64'hff00ff00ff00ff00);
  endfunction

  function automatic logic [DATA_W-1:0] swap32(input logic [DATA_W-1:0] v);
    swap32 = {v[39:32], v[47:40], v[55:48], v[63:56],
              v[7:0],   v[15:8],  v[23:16], v[31:24]};
  endfunction

  function automatic logic [DATA_W-1:0] swap64(input logic [DATA_W-1:0] v);
    swap64 = {v[7:0],   v[15:8],  v[23:16], v[31:24],
              v[39:32], v[47:40], v[55:48], v[63:56]};
  endfunction

  // Reversed layout: reverse the used bytes, lowest pair ends up highest.
  function automatic logic [DATA_W-1:0] bcd_reverse(input logic [DATA_W-1:0] d);
    logic [2:0] top;
    logic [2:0] gap;
    top = 3'd0;
    for (int i = 0; i < PAIRS; i++) begin
      if (d[8*i +: 8] != 8'h00) top = 3'(i);
    end
    gap = 3'd7 - top;
    bcd_reverse = swap64(d) >> {gap, 3'b000};
  endfunction

endpackage

### rtl/core/bsbcd_alu.sv
// Shared arithmetic unit: Horner step (x100 + pair) or a 4-bit double-dabble step.
// Depends on bsbcd_pkg.
module bsbcd_alu (
  input  bsbcd_pkg::alu_ctl_t          ctl_i,
  input  logic [bsbcd_pkg::DATA_W-1:0] acc_i,
  output logic [bsbcd_pkg::DATA_W-1:0] acc_o
);
  import bsbcd_pkg::*;

  logic [DATA_W-1:0] horner;
  logic [DATA_W-1:0] dabble;
  logic [7:0]        pair_bin;

  // nibbles above nine are weighted as they stand
  assign pair_bin = 8'({4'd0, ctl_i.pair[3:0]}) + {1'b0, ctl_i.pair[7:4], 3'b000}
                  + {3'b000, ctl_i.pair[7:4], 1'b0};

  assign horner = (acc_i << 6) + (acc_i << 5) + (acc_i << 2) + DATA_W'(pair_bin);

  always_comb begin
    logic [DATA_W-1:0] d;
    d = acc_i;
    for (int k = 0; k < NIB_STEP; k++) begin
      for (int j = 0; j < DATA_W / 4; j++) begin
        if (d[4*j +: 4] >= 4'd5) d[4*j +: 4] = d[4*j +: 4] + 4'd3;
      end
      d = {d[DATA_W-2:0], ctl_i.bits[NIB_STEP-1-k]};
    end
    dabble = d;
  end

  always_comb begin
    unique case (ctl_i.op)
      ALU_HORNER: acc_o = horner;
      ALU_DABBLE: acc_o = dabble;
    endcase
  end

endmodule

### rtl/core/byte_swap_and_bcd_converter_top.sv
// Top level: request handshake, sequencer and output register around bsbcd_alu.
// Depends on bsbcd_pkg, bsbcd_alu and byte_swap_and_bcd_converter_top_assert.svh.
//
//  channel | ports              | carries
//  --------+--------------------+-------------------------------------------
//  in      | in_tvalid/in_tready| tuser = mode, tdata = value
//  out     | out_tvalid/tready  | tdata = result, tuser = status
//
// From request to result: swaps, mode 7 and to-BCD overflow go straight to the finish state;
// from-BCD runs eight Horner steps, an end check and the load; reversed from-BCD one Horner
// step per byte up to the highest nonzero one; to-BCD 14 dabble steps of 4 bits, then layout.
// in_tready is high only while the sequencer is idle.
// A finished result waits in the sequencer until the output register is free.
// Reset (rst_n low, synchronous) empties the output register and idles the block.
module byte_swap_and_bcd_converter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bsbcd_pkg::DATA_W-1:0]  in_tdata,   // [63:0] value
  input  logic [bsbcd_pkg::MODE_W-1:0]  in_tuser,   // [2:0] mode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [bsbcd_pkg::DATA_W-1:0]  out_tdata,  // [63:0] result
  output logic [0:0]                    out_tuser   // [0] status
);
  import bsbcd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_HORNER,
    ST_FINISH
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] acc_r, acc_nxt;
  logic [DATA_W-1:0] src_r, src_nxt;
  logic              rev_r, rev_nxt;
  logic              hi_first_r, hi_first_nxt;
  logic              stat_r, stat_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_stat_r, out_stat_nxt;

  alu_ctl_t          alu_ctl;
  logic [DATA_W-1:0] alu_out;

  assign alu_ctl.op   = (state_r == ST_DABBLE) ? ALU_DABBLE : ALU_HORNER;
  assign alu_ctl.pair = hi_first_r ? src_r[DATA_W-1 -: 8] : src_r[7:0];
  assign alu_ctl.bits = src_r[DATA_W-1 -: NIB_STEP];

  bsbcd_alu u_alu (
    .ctl_i (alu_ctl),
    .acc_i (acc_r),
    .acc_o (alu_out)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    src_nxt       = src_r;
    rev_nxt       = rev_r;
    hi_first_nxt  = hi_first_r;
    stat_nxt      = stat_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_stat_nxt  = out_stat_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          stat_nxt  = 1'b0;
          rev_nxt   = 1'b0;
          state_nxt = ST_FINISH;
          unique case (in_tuser)
            MODE_SWAP16: acc_nxt = swap16(in_tdata);
            MODE_SWAP32: acc_nxt = swap32(in_tdata);
            MODE_SWAP64: acc_nxt = swap64(in_tdata);
            MODE_TO_BCD, MODE_TO_REV: begin
              acc_nxt = '0;
              if (in_tdata >= BCD_LIMIT) begin
                stat_nxt = 1'b1;
              end else begin
                src_nxt   = in_tdata << 8; // 56 significant bits, msb aligned
                cnt_nxt   = CNT_W'(DABBLE_STEPS);
                rev_nxt   = (in_tuser == MODE_TO_REV);
                state_nxt = ST_DABBLE;
              end
            end
            MODE_FROM_BCD: begin
              acc_nxt      = '0;
              src_nxt      = in_tdata;
              hi_first_nxt = 1'b1;
              cnt_nxt      = CNT_W'(PAIRS);
              state_nxt    = ST_HORNER;
            end
            MODE_FROM_REV: begin
              acc_nxt      = '0;
              src_nxt      = in_tdata;
              hi_first_nxt = 1'b0;
              state_nxt    = ST_HORNER;
            end
            default: acc_nxt = in_tdata;
          endcase
        end
      end
      ST_DABBLE: begin
        acc_nxt = alu_out;
        src_nxt = src_r << NIB_STEP;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) state_nxt = ST_FINISH;
      end
      ST_HORNER: begin
        // normal layout walks all pairs from the top; reversed stops at the last nonzero byte
        if (hi_first_r ? (cnt_r == '0) : (src_r == '0)) begin
          state_nxt = ST_FINISH;
        end else begin
          acc_nxt = alu_out;
          src_nxt = hi_first_r ? (src_r << 8) : (src_r >> 8);
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = rev_r ? bcd_reverse(acc_r) : acc_r;
          out_stat_nxt  = stat_r;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      rev_r       <= 1'b0;
      hi_first_r  <= 1'b0;
      stat_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      rev_r       <= rev_nxt;
      hi_first_r  <= hi_first_nxt;
      stat_r      <= stat_nxt;
    end
    acc_r      <= acc_nxt;
    src_r      <= src_nxt;
    out_data_r <= out_data_nxt;
    out_stat_r <= out_stat_nxt;
  end

`include "byte_swap_and_bcd_converter_top_assert.svh"

  `BSBCD_ASSERT_NEXT(a_busy_after_req, in_tvalid && in_tready, !in_tready, "ready after request")
  `BSBCD_ASSERT_NOW(a_ovf_zero, out_tvalid && out_tuser[0], out_tdata == '0, "overflow not zero")
  `BSBCD_ASSERT_NOW(a_load_from_finish, $rose(out_tvalid), $past(state_r == ST_FINISH), "stray load")

endmodule

### tb/byte_swap_and_bcd_converter_top_tb.sv
// Self-checking bench for byte_swap_and_bcd_converter_top: directed swap, pass-through and
// BCD cases, then mixed random requests under bursty input and output back-pressure.
// Depends on bsbcd_pkg and the RTL of the converter.
module byte_swap_and_bcd_converter_top_tb;
  import bsbcd_pkg::*;

  localparam logic [MODE_W-1:0] MODE_PASSTHRU = 3'd7;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int REPORT_LIMIT   = 10;
  localparam int RANDOM_ITEMS   = 1700;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] word;
    logic              status;
  } conversion_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata;   // [63:0] value
  logic [MODE_W-1:0] in_tuser;   // [2:0] mode
  logic              out_tvalid;
  logic              out_tready;
  logic [DATA_W-1:0] out_tdata;  // [63:0] result
  logic [0:0]        out_tuser;  // [0] status

  conversion_t pending_results[$];
  int          err_count   = 0;
  int          idle_cycles = 0;
  int          burst_left  = 0;
  bit          hold_req    = 1'b0;
  int          hold_left   = 0;
  int          stall_style = 0;
  int          style_age   = 0;
  int          pattern_cnt = 0;

  byte_swap_and_bcd_converter_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] pair_to_bcd(input logic [DATA_W-1:0] p);
    logic [7:0] q;
    q = p[7:0];
    return {4'(q / 10), 4'(q % 10)};
  endfunction

  // nibbles above nine are weighted as they stand
  function automatic logic [DATA_W-1:0] pair_value(input logic [7:0] b);
    return DATA_W'(b[3:0]) + DATA_W'(b[7:4]) * 64'd10;
  endfunction

  function automatic conversion_t convert_word(input logic [MODE_W-1:0] mode,
                                               input logic [DATA_W-1:0] value);
    conversion_t       c;
    logic [DATA_W-1:0] v;
    logic [DATA_W-1:0] r;
    logic [DATA_W-1:0] w;
    int                i;
    c.mode   = mode;
    c.value  = value;
    c.status = 1'b0;
    v = value;
    r = '0;
    w = 64'd1;
    case (mode)
      MODE_SWAP16: r = ((v >> 8) & 64'h00ff00ff00ff00ff) | ((v << 8) & 64'hff00ff00ff00ff00);
      MODE_SWAP32: begin
        for (i = 0; i < 8; i++) r[8*i +: 8] = v[8*((i & 4) + 3 - (i & 3)) +: 8];
      end
      MODE_SWAP64: begin
        for (i = 0; i < 8; i++) r[8*i +: 8] = v[8*(7 - i) +: 8];
      end
      MODE_TO_BCD, MODE_TO_REV: begin
        if (v >= BCD_LIMIT) begin
          c.status = 1'b1;
        end else if (mode == MODE_TO_BCD) begin
          for (i = 0; v != 0 && i < 8; i++) begin
            r[8*i +: 8] = pair_to_bcd(v % 64'd100);
            v = v / 64'd100;
          end
        end else begin
          // lowest pair is shifted up past every higher pair
          do begin
            r = r | DATA_W'(pair_to_bcd(v % 64'd100));
            v = v / 64'd100;
            if (v != 0) r = r << 8;
          end while (v != 0);
        end
      end
      MODE_FROM_BCD: begin
        while (v != 0) begin
          r = r + pair_value(v[7:0]) * w;
          w = w * 64'd100;
          v = v >> 8;
        end
      end
      MODE_FROM_REV: begin
        while (v != 0) begin
          r = r * 64'd100 + pair_value(v[7:0]);
          v = v >> 8;
        end
      end
      default: r = v;
    endcase
    c.word = r;
    return c;
  endfunction

  // expectations are taken on input acceptance, results retired in order
  always @(posedge clk) begin
    conversion_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        if (err_count < REPORT_LIMIT)
          $display("unexpected result %h status %b", out_tdata, out_tuser[0]);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata !== want.word || out_tuser[0] !== want.status) begin
          if (err_count < REPORT_LIMIT)
            $display("mismatch mode %0d value %h: expected %h/%b, got %h/%b",
                     want.mode, want.value, want.word, want.status,
                     out_tdata, out_tuser[0]);
          err_count++;
        end
      end
    end
    if (rst_n && in_tvalid && in_tready)
      pending_results.push_back(convert_word(in_tuser, in_tdata));
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: stall style changes every so often; a requested hold-off overrides it
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    pattern_cnt++;
    style_age++;
    if (style_age >= 96) begin
      style_age   = 0;
      stall_style = $urandom_range(0, 3);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (stall_style)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= pattern_cnt[2];
      endcase
    end
  end

  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] value);
    int gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic make_random_item(output logic [MODE_W-1:0] mode,
                                  output logic [DATA_W-1:0] value);
    int                pick;
    int                digits;
    logic [DATA_W-1:0] v;
    if ($urandom_range(0, 99) < 3) mode = MODE_PASSTHRU;
    else mode = MODE_W'($urandom_range(0, 6));
    pick = $urandom_range(0, 9);
    v = {$urandom, $urandom};
    case (mode)
      MODE_TO_BCD, MODE_TO_REV: begin
        if (pick < 7) begin
          digits = $urandom_range(1, 16);
          v = '0;
          repeat (digits) v = v * 64'd10 + 64'($urandom_range(0, 9));
          // trailing zero pairs for the reversed layout
          if (digits <= 12 && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) v = v * 64'd100;
        end else if (pick < 9) begin
          v = BCD_LIMIT - 64'd2 + 64'($urandom_range(0, 3));
        end
      end
      MODE_FROM_BCD, MODE_FROM_REV: begin
        if (pick < 8) begin
          v = '0;
          repeat ($urandom_range(1, 8))
            v = {v[55:0], 4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
          if ($urandom_range(0, 2) == 0) v = v << (8 * $urandom_range(1, 3));
        end
      end
      default: ;
    endcase
    value = v;
  endtask

  task automatic test_swaps();
    send_item(MODE_SWAP16, 64'h0123456789abcdef);
    send_item(MODE_SWAP32, 64'h0123456789abcdef);
    send_item(MODE_SWAP64, 64'h0123456789abcdef);
    send_item(MODE_SWAP16, 64'hffff0000ffff00ff);
  endtask

  task automatic test_passthrough();
    send_item(MODE_PASSTHRU, 64'h0);
    send_item(MODE_PASSTHRU, 64'hffffffffffffffff);
  endtask

  task automatic test_to_bcd();
    send_item(MODE_TO_BCD, 64'd0);
    send_item(MODE_TO_BCD, BCD_LIMIT - 64'd1);
    send_item(MODE_TO_BCD, BCD_LIMIT);
    send_item(MODE_TO_BCD, 64'hffffffffffffffff);
    send_item(MODE_TO_REV, 64'd0);
    send_item(MODE_TO_REV, 64'd100);
    send_item(MODE_TO_REV, 64'd1234567890123456);
    send_item(MODE_TO_REV, BCD_LIMIT);
  endtask

  task automatic test_from_bcd();
    send_item(MODE_FROM_BCD, 64'h0);
    send_item(MODE_FROM_BCD, 64'h9999999999999999);
    send_item(MODE_FROM_BCD, 64'hffffffffffffffff);
    send_item(MODE_FROM_REV, 64'h0);
    send_item(MODE_FROM_REV, 64'h01);
    send_item(MODE_FROM_REV, 64'h0000000001000000);
    send_item(MODE_FROM_REV, 64'hffffffffffffffff);
  endtask

  task automatic test_random_traffic(input int count);
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] value;
    repeat (count) begin
      make_random_item(mode, value);
      send_item(mode, value);
    end
  endtask

  // output held off while requests keep coming, so the input stalls
  task automatic test_output_hold_off();
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] value;
    wait_drained();
    hold_req = 1'b1;
    repeat (60) begin
      make_random_item(mode, value);
      send_item(mode, value);
    end
  endtask

  task automatic test_drain_pause();
    repeat (4) begin
      test_random_traffic(30);
      wait_drained();
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_swaps();
    test_passthrough();
    test_to_bcd();
    test_from_bcd();
    test_random_traffic(RANDOM_ITEMS);
    test_output_hold_off();
    test_drain_pause();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/bsbcd_pkg.sv
rtl/core/bsbcd_alu.sv
rtl/core/byte_swap_and_bcd_converter_top.sv
tb/byte_swap_and_bcd_converter_top_tb.sv
